@@ design/sirc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sirc_pkg;

  // Field widths and sizes.
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int BIT_W       = $clog2(VALUE_WIDTH);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

  // Radix limits; values outside saturate to the nearest limit.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = CHAR_W'(8'h2D);
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(8'h41);
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] DIGIT_TOP      = RADIX_W'(35);

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic quot_zero;
  } div_status_t;

  // Maps a digit value to its ASCII character, 0-9 then A-Z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] dc;
    dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
    if (dc < DECIMAL_DIGITS) begin
      return CHAR_ZERO + CHAR_W'(dc);
    end
    return CHAR_LETTER + CHAR_W'(dc - DECIMAL_DIGITS);
  endfunction

endpackage

`default_nettype wire

@@ design/sirc_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module sirc_divider import sirc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]     divisor_i,
  output logic      [VALUE_WIDTH-1:0] quotient_o,
  output logic      [RADIX_W-1:0]     remainder_o,
  output div_status_t                 status_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [RADIX_W-1:0]     rem_q;
  logic [RADIX_W-1:0]     div_q;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   fits;

  // One step of long division: bring down the next bit and try a subtract.
  assign trial = {rem_q, mag_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // Step counter and completion pulse.
  always_comb begin
    busy_d = busy_q;
    bit_d  = bit_q;
    done_d = busy_q && (bit_q == '0);
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BIT_W'(VALUE_WIDTH - 1);
    end else if (busy_q) begin
      bit_d = bit_q - BIT_W'(1);
      if (bit_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end
  end

  assign quotient_o         = mag_q;
  assign remainder_o        = rem_q;
  assign status_o.busy      = busy_q;
  assign status_o.done      = done_q;
  assign status_o.quot_zero = (mag_q == '0);

endmodule

`default_nettype wire

@@ design/signed_integer_to_radix_digits.sv @@
// Converts a signed 32-bit number to its ASCII text in a radix from 2 to 36
// (other radix codes saturate to the nearest limit), most significant
// character first, with a leading '-' for negative values, '0' for zero and
// last_o set on the final character. One number is handled at a time. Each
// digit is divided out by the restoring divider, one quotient bit per cycle.
// Each digit character is then read back from the digit store (S_RD), turned
// into a character (S_LOAD) and handed to the output register (S_PUT), and
// the minus sign goes straight to the output register. The block takes no new
// number until the last character of the current one has been loaded, and a
// stalled output holds it in S_PUT. The digit store needs no clearing after
// reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_radix_digits import sirc_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0] number_i,
  input  wire logic        [RADIX_W-1:0]     radix_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic             [CHAR_W-1:0]      char_code_o,
  output logic                               last_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_LOAD = 5'b01000,
    S_PUT  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic [RADIX_W-1:0]     radix_q, radix_d;
  logic [CHAR_W-1:0]      pend_char_q, pend_char_d;
  logic                   pend_last_q, pend_last_d;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;
  logic [RADIX_W-1:0]     store_q [MAX_DIGITS];
  logic [RADIX_W-1:0]     rd_data_q;

  logic                   in_acc;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [RADIX_W-1:0]     radix_sat;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [RADIX_W-1:0]     divisor;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [RADIX_W-1:0]     remainder;
  div_status_t            div_st;
  logic                   wr_en;
  logic                   rd_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   out_load;
  logic [COUNT_W-1:0]     cnt_dec;

  // Input decode: magnitude as unsigned so the most negative value is exact.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign raw        = number_i;
  assign neg_in     = raw[VALUE_WIDTH-1];
  assign mag_in     = neg_in ? (~raw + VALUE_WIDTH'(1)) : raw;

  always_comb begin
    radix_sat = radix_i;
    if (radix_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end
  end

  sirc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .status_o    (div_st)
  );

  assign cnt_dec = cnt_q - COUNT_W'(1);
  assign wr_addr = cnt_q[ADDR_W-1:0];
  assign rd_addr = cnt_dec[ADDR_W-1:0];

  // Sequencer: divide out digits, emit any minus sign, then read the digits back in reverse; a zero goes straight out.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    pend_char_d = pend_char_q;
    pend_last_d = pend_last_q;
    div_start   = 1'b0;
    dividend    = quotient;
    divisor     = radix_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (raw == '0) begin
            pend_char_d = CHAR_ZERO;
            pend_last_d = 1'b1;
            state_d     = S_PUT;
          end else begin
            div_start = 1'b1;
            dividend  = mag_in;
            divisor   = radix_sat;
            radix_d   = radix_sat;
            neg_d     = neg_in;
            cnt_d     = '0;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + COUNT_W'(1);
          if (div_st.quot_zero || (cnt_q == COUNT_W'(MAX_DIGITS - 1))) begin
            if (neg_q) begin
              pend_char_d = CHAR_MINUS;
              pend_last_d = 1'b0;
              state_d     = S_PUT;
            end else begin
              state_d = S_RD;
            end
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        pend_char_d = digit_char(rd_data_q);
        pend_last_d = (cnt_q == COUNT_W'(1));
        cnt_d       = cnt_dec;
        state_d     = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = pend_last_q ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    neg_q       <= neg_d;
    radix_q     <= radix_d;
    pend_char_q <= pend_char_d;
    pend_last_q <= pend_last_d;
    if (out_load) begin
      char_q <= pend_char_q;
      last_q <= pend_last_q;
    end
  end

  // Digit store, least significant digit at the lowest address.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= remainder;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // The divider only runs while digits are being produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_DIV))
    else $error("divider busy outside the divide phase");

  // A zero input goes straight to a single '0' character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (raw == '0)) |=> ((state_q == S_PUT) && pend_char_q == CHAR_ZERO && pend_last_q))
    else $error("zero input not turned into a lone zero character");

  // The digit count never runs past the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= COUNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  // Digits are read back only when some remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (cnt_q != '0))
    else $error("digit read with an empty store");

endmodule

`default_nettype wire

@@ tb/sv/sirc_text_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the radix text converter, spells out every accepted
// number in its own predictor and compares each output beat against the text
// it expects next.
module sirc_text_checker import sirc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [VALUE_WIDTH-1:0] number_i,
  input  logic        [RADIX_W-1:0]     radix_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic        [CHAR_W-1:0]      char_code_i,
  input  logic                          last_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_chars_o,
  output int unsigned                   chars_checked_o
);

  // Keep the log readable if the design is badly broken; every mismatch still counts.
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Characters still owed by the design, oldest first.
  text_char_t  pending_text[$];
  int unsigned mismatch_total;
  int unsigned chars_checked;

  initial begin
    mismatch_total = 0;
    chars_checked  = 0;
  end

  assign mismatches_o    = mismatch_total;
  assign chars_checked_o = chars_checked;

  task automatic report_mismatch(input string what);
    if (mismatch_total < PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_total++;
  endtask

  // Appends the text of one number to the expected characters.
  function automatic void spell_number(input logic [VALUE_WIDTH-1:0] value,
                                       input logic [RADIX_W-1:0] radix_code);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [RADIX_W-1:0]     base;
    logic [RADIX_W-1:0]     digits [MAX_DIGITS];
    logic [RADIX_W-1:0]     d;
    logic                   negative;
    int                     count;
    text_char_t             c;
    // Out-of-range radix codes clamp to the nearest supported base.
    if (radix_code < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_code > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_code;
    end
    negative = value[VALUE_WIDTH-1];
    if (value == '0) begin
      c.code = CHAR_ZERO;
      c.last = 1'b1;
      pending_text.push_back(c);
      return;
    end
    // Unsigned negation gives the right magnitude even for the most negative value.
    magnitude = negative ? (VALUE_WIDTH'(0) - value) : value;
    count = 0;
    while (magnitude != '0 && count < MAX_DIGITS) begin
      digits[count] = RADIX_W'(magnitude % VALUE_WIDTH'(base));
      magnitude     = magnitude / VALUE_WIDTH'(base);
      count++;
    end
    if (negative) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      pending_text.push_back(c);
    end
    // Digits were found least significant first, so read them back in reverse.
    for (int i = count - 1; i >= 0; i--) begin
      d = digits[i];
      if (d < DECIMAL_DIGITS) begin
        c.code = CHAR_ZERO + CHAR_W'(d);
      end else begin
        c.code = CHAR_LETTER + CHAR_W'(d - DECIMAL_DIGITS);
      end
      c.last = (i == 0);
      pending_text.push_back(c);
    end
  endfunction

  // Both handshakes are sampled at the rising edge, where the stimulus changes.
  always @(posedge clk_i) begin : watch_beats
    text_char_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        spell_number(number_i, radix_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_text.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h (last %b) with no number waiting",
                                    char_code_i, last_i));
        end else begin
          want = pending_text.pop_front();
          chars_checked++;
          if (char_code_i !== want.code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h (%c)",
                                      char_code_i, want.code, want.code));
          end
          if (last_i !== want.last) begin
            report_mismatch($sformatf("last %b on char 0x%02h, expected %b",
                                      last_i, want.code, want.last));
          end
        end
      end
    end
    pending_chars_o <= pending_text.size();
  end

endmodule

@@ tb/sv/tb_signed_integer_to_radix_digits.sv @@
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_digits;
  import sirc_pkg::*;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_NUMBERS = 445;
  localparam int LONG_HOLD      = 1500;
  localparam int DRAIN_CYCLES   = 50;
  localparam int TIMEOUT_NS     = 40_000_000;

  localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = ~MOST_NEGATIVE;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] number;
  logic        [RADIX_W-1:0]     radix;
  logic                          out_valid;
  logic                          out_ready;
  logic        [CHAR_W-1:0]      char_code;
  logic                          last;

  int unsigned mismatches;
  int unsigned pending_chars;
  int unsigned chars_checked;

  int numbers_sent;
  int negatives_sent;
  int clamped_radices;
  int long_holds;
  int sender_calm;

  always #(CLK_HALF_NS) clk = ~clk;

  signed_integer_to_radix_digits dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .number_i    (number),
    .radix_i     (radix),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .char_code_o (char_code),
    .last_o      (last)
  );

  sirc_text_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .number_i        (number),
    .radix_i         (radix),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .char_code_i     (char_code),
    .last_i          (last),
    .mismatches_o    (mismatches),
    .pending_chars_o (pending_chars),
    .chars_checked_o (chars_checked)
  );

  // Idle length after a beat: mostly none or short, now and then long, with
  // occasional calm stretches where no idling happens at all.
  task automatic draw_gap(inout int calm_left, output int gap);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if (roll < 45) begin
      gap = 0;
    end else if (roll < 88) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (calm_left == 0 && $urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
  endtask

  // Offers one number, waits for the beat to go through, then idles a while.
  task automatic send_number(input logic signed [VALUE_WIDTH-1:0] value,
                             input logic [RADIX_W-1:0] radix_code);
    int gap;
    in_valid <= 1'b1;
    number   <= value;
    radix    <= radix_code;
    do @(posedge clk); while (!(in_valid && in_ready));
    numbers_sent++;
    if (value < 0) negatives_sent++;
    if (radix_code < RADIX_MIN || radix_code > RADIX_MAX) clamped_radices++;
    draw_gap(sender_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random values lean on zero, small magnitudes, the extremes and powers of two.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_number();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1, 2:    v = VALUE_WIDTH'($urandom_range(1, 1000));
      3:       v = MOST_NEGATIVE + VALUE_WIDTH'($urandom_range(0, 2));
      4:       v = MOST_POSITIVE - VALUE_WIDTH'($urandom_range(0, 2));
      5:       v = VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    logic [RADIX_W-1:0] r;
    case ($urandom_range(0, 9))
      0:       r = RADIX_W'($urandom_range(0, (1 << RADIX_W) - 1));
      1:       r = ($urandom_range(0, 1) == 1) ? RADIX_MIN : RADIX_MAX;
      default: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endcase
    return r;
  endfunction

  // Output side: random stalls, plus two long hold-offs that back the block up.
  initial begin : drain_output
    int hold;
    int calm;
    int beats;
    out_ready <= 1'b0;
    hold  = 0;
    calm  = 0;
    beats = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        beats++;
        if (beats == 200 || beats == 2500) begin
          hold = LONG_HOLD;
          long_holds++;
        end else begin
          draw_gap(calm, hold);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : run_test
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    number          <= '0;
    radix           <= '0;
    numbers_sent    = 0;
    negatives_sent  = 0;
    clamped_radices = 0;
    long_holds      = 0;
    sender_calm     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, the extremes, digit letters and out-of-range radix codes.
    send_number('0, RADIX_W'(10));
    send_number('0, RADIX_W'(0));
    send_number(-1, RADIX_W'(10));
    send_number(1, RADIX_MIN);
    send_number(MOST_POSITIVE, RADIX_MIN);
    send_number(MOST_NEGATIVE, RADIX_MIN);
    send_number(MOST_NEGATIVE, RADIX_W'(10));
    send_number(MOST_POSITIVE, RADIX_W'(10));
    send_number(MOST_POSITIVE, RADIX_MAX);
    send_number(MOST_NEGATIVE, RADIX_MAX);
    send_number(35, RADIX_MAX);
    send_number(-35, RADIX_MAX);
    send_number(36, RADIX_MAX);
    send_number(1295, RADIX_MAX);
    send_number(9, RADIX_W'(10));
    send_number(10, RADIX_W'(10));
    send_number(255, RADIX_W'(16));
    send_number(-255, RADIX_W'(16));
    send_number(5, RADIX_W'(0));
    send_number(-5, RADIX_W'(1));
    send_number(100, RADIX_W'(37));
    send_number(-100, RADIX_W'(63));
    send_number(12345678, RADIX_W'(7));
    send_number(-2, RADIX_MIN);
    send_number(MOST_NEGATIVE + 1, RADIX_W'(3));

    repeat (RANDOM_NUMBERS) send_number(pick_number(), pick_radix());
    in_valid <= 1'b0;

    // Every number makes at least one character, so an empty queue means idle.
    do @(negedge clk); while (pending_chars != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d numbers (%0d negative, %0d with clamped radix) into %0d characters.",
             numbers_sent, negatives_sent, clamped_radices, chars_checked);
    $display("Output was held off for %0d cycles %0d time(s) while numbers kept arriving.",
             LONG_HOLD, long_holds);
    if (mismatches == 0 && pending_chars == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/sirc_pkg.sv
design/sirc_divider.sv
design/signed_integer_to_radix_digits.sv
tb/sv/sirc_text_checker.sv
tb/sv/tb_signed_integer_to_radix_digits.sv
